// ===== rtl/core/pjb_pkg.sv =====
// Shared types and constants for the packet jitter buffer.
package pjb_pkg;

    // NUM_SLOTS is a power of two: the slot index is the low sequence bits
    localparam int NUM_SLOTS   = 32;
    localparam int WALK_LIMIT  = 256;
    localparam int MAX_RESULTS = 32;

    localparam int SEQ_W  = 32;
    localparam int TIME_W = 64;
    localparam int HDL_W  = 16;
    localparam int REQ_W  = 2;
    localparam int TGT_W  = 7;

    localparam logic [TGT_W-1:0] TGT_RESET = TGT_W'(4);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W  = (CNT_W > TGT_W + 1) ? CNT_W : TGT_W + 1;
    localparam int STEP_W = $clog2(WALK_LIMIT + 1);
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_DRAIN = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_RD,
        ST_PUSH_EV,
        ST_WALK_CHK,
        ST_WALK_EV,
        ST_WALK_END
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] ts;
        logic [HDL_W-1:0]  hdl;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

endpackage

// ===== rtl/core/pjb_ifs.sv =====
// Request and release channel interfaces of the packet jitter buffer.
interface pjb_req_if;
    logic                       valid;
    logic                       ready;
    logic [pjb_pkg::REQ_W-1:0]  req_type;
    logic [pjb_pkg::SEQ_W-1:0]  sequence_req;
    logic [pjb_pkg::TIME_W-1:0] capture_time;
    logic [pjb_pkg::HDL_W-1:0]  payload_handle;

    modport source (output valid, req_type, sequence_req, capture_time, payload_handle,
                    input ready);
    modport sink   (input valid, req_type, sequence_req, capture_time, payload_handle,
                    output ready);
endinterface

interface pjb_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [pjb_pkg::SEQ_W-1:0]  out_sequence;
    logic [pjb_pkg::TIME_W-1:0] out_capture_time;
    logic [pjb_pkg::HDL_W-1:0]  out_payload_handle;
    logic                       last_frame;

    modport source (output valid, out_sequence, out_capture_time, out_payload_handle,
                    last_frame, input ready);
    modport sink   (input valid, out_sequence, out_capture_time, out_payload_handle,
                    last_frame, output ready);
endinterface

// ===== rtl/core/pjb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/packet_jitter_buffer.sv =====
// Packet jitter buffer: reorder store with in-order release of packet descriptors.
//
//  channel       dir  handshake               carries
//  i_req         in   valid/ready             req_type, sequence_req, capture_time,
//                                             payload_handle
//  o_rsp         out  valid/ready             out_sequence, out_capture_time,
//                                             out_payload_handle, last_frame
//  i_cfg_wr_*    in   write enable, no wait   target_depth
//
//  Push: accept (slot index is the low sequence bits), slot RAM read, then
//  compare/write. Clear, no-op codes and drains that start no walk end at accept.
//  Drain: accept, then per walk step a slot RAM read and an evaluate, at most
//  WALK_LIMIT steps and MAX_RESULTS releases, then closing steps (last bound
//  check, flush of the held frame).
//  i_req.ready is high only while idle. A release stalls while o_rsp holds an untaken
//  transaction and one frame is already pending behind it.
//  Reset (synchronous, active low) clears the valid bits, count and sequence state
//  at once; slot contents are not cleared.
module packet_jitter_buffer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    pjb_req_if.sink                   i_req,
    pjb_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_wr_en,
    input  logic [pjb_pkg::TGT_W-1:0] i_cfg_wr_data
);
    import pjb_pkg::*;

    t_state               r_state, n_state;
    logic [TGT_W-1:0]     r_target, n_target;
    logic [NUM_SLOTS-1:0] r_slot_valid, n_slot_valid;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [SEQ_W-1:0]     r_exp, n_exp;
    logic [SLOT_W-1:0]    r_exp_idx, n_exp_idx;
    logic                 r_exp_set, n_exp_set;
    logic                 r_primed, n_primed;

    // push transaction and its slot index
    t_slot                r_push, n_push;
    logic [SLOT_W-1:0]    r_mod_r, n_mod_r;

    // walk bookkeeping
    logic [STEP_W-1:0]    r_steps, n_steps;
    logic [NRES_W-1:0]    r_nres, n_nres;

    // one released frame held back until it is known whether it is the last
    t_slot                r_pend, n_pend;
    logic                 r_pend_valid, n_pend_valid;

    // output register
    t_slot                r_out, n_out;
    logic                 r_out_last, n_out_last;
    logic                 r_out_valid, n_out_valid;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [SLOT_BITS-1:0] ram_rdata;
    t_slot                rd;
    logic                 out_free;
    logic                 emit;
    logic                 emit_last;
    logic [CMP_W-1:0]     cnt_x;
    logic [CMP_W-1:0]     tgt_x;
    logic [CMP_W-1:0]     tgt2_x;
    logic                 hit;

    pjb_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_mod_r),
        .i_wdata (r_push),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd        = t_slot'(ram_rdata);
    // push reads the slot it will write; otherwise the walk's current slot
    assign ram_raddr = (r_state == ST_PUSH_RD) ? r_mod_r : r_exp_idx;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign cnt_x     = CMP_W'(r_count);
    assign tgt_x     = CMP_W'(r_target);
    assign tgt2_x    = CMP_W'({r_target, 1'b0});
    assign hit       = r_slot_valid[r_exp_idx] && (rd.seq == r_exp);

    assign i_req.ready              = (r_state == ST_IDLE);
    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.out_sequence       = r_out.seq;
    assign o_rsp.out_capture_time   = r_out.ts;
    assign o_rsp.out_payload_handle = r_out.hdl;
    assign o_rsp.last_frame         = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_target     = i_cfg_wr_en ? i_cfg_wr_data : r_target;
        n_slot_valid = r_slot_valid;
        n_count      = r_count;
        n_exp        = r_exp;
        n_exp_idx    = r_exp_idx;
        n_exp_set    = r_exp_set;
        n_primed     = r_primed;
        n_push       = r_push;
        n_mod_r      = r_mod_r;
        n_steps      = r_steps;
        n_nres       = r_nres;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        ram_we       = 1'b0;
        emit         = 1'b0;
        emit_last    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    unique case (i_req.req_type)
                        REQ_PUSH: begin
                            n_push  = '{seq: i_req.sequence_req, ts: i_req.capture_time,
                                        hdl: i_req.payload_handle};
                            // sequence modulo the slot count
                            n_mod_r = i_req.sequence_req[SLOT_W-1:0];
                            n_state = ST_PUSH_RD;
                        end
                        REQ_DRAIN: begin
                            if (r_exp_set && r_count != '0 &&
                                (r_primed || !(cnt_x < tgt_x))) begin
                                n_primed = 1'b1;
                                n_steps  = '0;
                                n_nres   = '0;
                                n_state  = ST_WALK_CHK;
                            end
                        end
                        REQ_CLEAR: begin
                            n_slot_valid = '0;
                            n_count      = '0;
                            n_exp        = '0;
                            n_exp_idx    = '0;
                            n_exp_set    = 1'b0;
                            n_primed     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PUSH_RD: begin
                n_state = ST_PUSH_EV;
            end
            ST_PUSH_EV: begin
                if (!r_exp_set) begin
                    n_exp     = r_push.seq;
                    n_exp_idx = r_mod_r;
                    n_exp_set = 1'b1;
                end
                // exact duplicate is dropped; another occupant is replaced
                if (!(r_slot_valid[r_mod_r] && rd.seq == r_push.seq)) begin
                    ram_we                = 1'b1;
                    n_slot_valid[r_mod_r] = 1'b1;
                    if (!r_slot_valid[r_mod_r]) begin
                        n_count = r_count + 1'b1;
                    end
                end
                n_state = ST_IDLE;
            end
            ST_WALK_CHK: begin
                if (r_count != '0 && r_steps < STEP_W'(WALK_LIMIT) &&
                    r_nres < NRES_W'(MAX_RESULTS)) begin
                    n_steps = r_steps + 1'b1;
                    n_state = ST_WALK_EV;
                end else begin
                    n_state = ST_WALK_END;
                end
            end
            ST_WALK_EV: begin
                priority if (hit) begin
                    if (!r_pend_valid || out_free) begin
                        emit                    = r_pend_valid;
                        n_pend                  = rd;
                        n_pend_valid            = 1'b1;
                        n_slot_valid[r_exp_idx] = 1'b0;
                        n_count                 = r_count - 1'b1;
                        n_nres                  = r_nres + 1'b1;
                        n_state                 = ST_WALK_CHK;
                    end
                end else if (cnt_x > tgt2_x) begin
                    n_state = ST_WALK_CHK;
                end else begin
                    n_state = ST_WALK_END;
                end
                // advance the expected sequence on a release or a skip
                if ((hit && (!r_pend_valid || out_free)) || (!hit && cnt_x > tgt2_x)) begin
                    n_exp = r_exp + 1'b1;
                    if (r_exp == '1 || r_exp_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                        n_exp_idx = '0;
                    end else begin
                        n_exp_idx = r_exp_idx + 1'b1;
                    end
                end
            end
            ST_WALK_END: begin
                if (r_pend_valid) begin
                    if (out_free) begin
                        emit         = 1'b1;
                        emit_last    = 1'b1;
                        n_pend_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out      = emit ? r_pend : r_out;
        n_out_last = emit ? emit_last : r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_target     <= TGT_RESET;
            r_slot_valid <= '0;
            r_count      <= '0;
            r_exp        <= '0;
            r_exp_idx    <= '0;
            r_exp_set    <= 1'b0;
            r_primed     <= 1'b0;
            r_steps      <= '0;
            r_nres       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_target     <= n_target;
            r_slot_valid <= n_slot_valid;
            r_count      <= n_count;
            r_exp        <= n_exp;
            r_exp_idx    <= n_exp_idx;
            r_exp_set    <= n_exp_set;
            r_primed     <= n_primed;
            r_steps      <= n_steps;
            r_nres       <= n_nres;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_push     <= n_push;
        r_mod_r    <= n_mod_r;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

`ifndef ASSERT_OFF
    // the count tracks the occupied slots exactly
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_slot_valid)))
        else $error("stored count differs from number of valid slots");

    // entries only exist once an expected sequence is known
    a_count_needs_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_exp_set)
        else $error("entries stored without an expected sequence");

    // no frame is held back across idle
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("pending frame left behind after a drain");

    // walk bounds
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_steps <= STEP_W'(WALK_LIMIT)) && (r_nres <= NRES_W'(MAX_RESULTS)))
        else $error("drain walk exceeded its bounds");

    // a clear empties the store on the next cycle
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.req_type == REQ_CLEAR)
        |=> (r_count == '0 && !r_exp_set && !r_primed && r_slot_valid == '0))
        else $error("clear did not empty the store");
`endif

endmodule

// ===== test/pjb_frame_order_checker.sv =====
`timescale 1ns / 1ps
// Checker: mirrors the reorder store, predicts released frames and compares them.
module pjb_frame_order_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    pjb_req_if                        i_req,
    pjb_rsp_if                        i_rsp,
    input  logic                      i_cfg_wr_en,
    input  logic [pjb_pkg::TGT_W-1:0] i_cfg_wr_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    import pjb_pkg::*;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] ts;
        logic [HDL_W-1:0]  hdl;
        logic              last;
    } t_frame;

    logic             slot_live [NUM_SLOTS];
    t_slot            slot_data [NUM_SLOTS];
    int               live_count;
    logic [SEQ_W-1:0] next_seq;
    logic             next_seq_known;
    logic             primed;
    logic [TGT_W-1:0] depth;
    t_frame           expected_frames [$];
    t_frame           head_frame;
    int               fail_count = 0;

    function automatic void forget_all();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_live[i] = 1'b0;
        end
        live_count     = 0;
        next_seq       = '0;
        next_seq_known = 1'b0;
        primed         = 1'b0;
    endfunction

    function automatic void store_frame(input t_slot f);
        int idx;
        idx = int'(f.seq % NUM_SLOTS);
        if (!next_seq_known) begin
            next_seq       = f.seq;
            next_seq_known = 1'b1;
        end
        // exact duplicate keeps the first copy
        if (slot_live[idx] && slot_data[idx].seq == f.seq) begin
            return;
        end
        // an occupant with another sequence is evicted: count unchanged
        if (!slot_live[idx]) begin
            live_count++;
        end
        slot_data[idx] = f;
        slot_live[idx] = 1'b1;
    endfunction

    function automatic void release_in_order();
        t_frame burst [MAX_RESULTS];
        int     n;
        int     steps;
        int     idx;
        logic   walking;
        n       = 0;
        steps   = 0;
        walking = 1'b1;
        if (!next_seq_known || live_count == 0) begin
            return;
        end
        if (!primed) begin
            if (live_count < int'(depth)) begin
                return;
            end
            primed = 1'b1;
        end
        while (walking && live_count > 0 && steps < WALK_LIMIT && n < MAX_RESULTS) begin
            idx = int'(next_seq % NUM_SLOTS);
            steps++;
            if (slot_live[idx] && slot_data[idx].seq == next_seq) begin
                burst[n].seq  = slot_data[idx].seq;
                burst[n].ts   = slot_data[idx].ts;
                burst[n].hdl  = slot_data[idx].hdl;
                burst[n].last = 1'b0;
                n++;
                slot_live[idx] = 1'b0;
                live_count--;
                next_seq++;
            end else if (live_count > 2 * int'(depth)) begin
                next_seq++;   // overfull: step over the hole
            end else begin
                walking = 1'b0;
            end
        end
        for (int i = 0; i < n; i++) begin
            burst[i].last   = (i == n - 1);
            expected_frames = {expected_frames, burst[i]};
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            forget_all();
            depth = TGT_RESET;
            expected_frames.delete();
        end else begin
            if (i_cfg_wr_en) begin
                depth = i_cfg_wr_data;
            end
            if (i_req.valid && i_req.ready) begin
                case (i_req.req_type)
                    REQ_PUSH: begin
                        store_frame('{seq: i_req.sequence_req, ts: i_req.capture_time,
                                      hdl: i_req.payload_handle});
                    end
                    REQ_DRAIN: begin
                        release_in_order();
                    end
                    REQ_CLEAR: begin
                        forget_all();
                    end
                    default: begin
                    end
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_frames.size() == 0) begin
                    $error("release with no frame expected: out_sequence %h",
                           i_rsp.out_sequence);
                    fail_count++;
                end else begin
                    head_frame = expected_frames.pop_front();
                    if (i_rsp.out_sequence !== head_frame.seq) begin
                        $error("out_sequence: expected %h, got %h",
                               head_frame.seq, i_rsp.out_sequence);
                        fail_count++;
                    end
                    if (i_rsp.out_capture_time !== head_frame.ts) begin
                        $error("out_capture_time: expected %h, got %h",
                               head_frame.ts, i_rsp.out_capture_time);
                        fail_count++;
                    end
                    if (i_rsp.out_payload_handle !== head_frame.hdl) begin
                        $error("out_payload_handle: expected %h, got %h",
                               head_frame.hdl, i_rsp.out_payload_handle);
                        fail_count++;
                    end
                    if (i_rsp.last_frame !== head_frame.last) begin
                        $error("last_frame: expected %b, got %b",
                               head_frame.last, i_rsp.last_frame);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= expected_frames.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== test/tb_packet_jitter_buffer.sv =====
`timescale 1ns / 1ps
// Testbench top: request and depth stimulus, response back-pressure and verdict.
module tb_packet_jitter_buffer;
    import pjb_pkg::*;

    // request code the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int PHASE_ITEMS   = 40;
    // a drain can walk WALK_LIMIT empty steps after its last frame; give it time
    // for that plus margin before touching the register
    localparam int SETTLE_CYCLES = 600;
    // cycles without any accepted transaction before the run is declared hung
    localparam int IDLE_LIMIT    = 4000;
    localparam int NUM_PHASES    = 8;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [TGT_W-1:0] cfg_wr_data = '0;
    logic             rsp_ready   = 1'b0;
    logic             steady      = 1'b0;   // no gaps, no stalls while set
    int               rsp_hold    = 0;
    int               idle_cycles = 0;
    int               items_sent  = 0;
    int               fail_count;
    int               pending;
    logic [SEQ_W-1:0] win_next;             // next in-order sequence of the stream
    logic [SEQ_W-1:0] last_pushed;

    // depth per random phase: both extremes, skip-heavy small values, mid values
    logic [TGT_W-1:0] phase_depth [NUM_PHASES] = '{7'd64, 7'd1, 7'd2, 7'd16,
                                                   7'd3, 7'd8, 7'd0, 7'd4};

    pjb_req_if req_if ();
    pjb_rsp_if rsp_if ();
    assign rsp_if.ready = rsp_ready;

    packet_jitter_buffer i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_if),
        .o_rsp         (rsp_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    pjb_frame_order_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #6 clk = ~clk;

    // mostly back-to-back, sometimes a few cycles, rarely a long hole
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    // response back-pressure: random stall runs unless the phase is steady
    always @(posedge clk) begin
        if (rsp_hold != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= rsp_hold - 1;
        end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) begin
                rsp_hold <= pick_stall();
            end
        end
    end

    // hang detector: any transaction, register write or reset restarts the count
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            cfg_wr_en || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One request transaction. valid stays high after acceptance so the next
    // call can follow back-to-back; it drops when a gap is chosen or settle() stops.
    task automatic send(input logic [REQ_W-1:0] code, input logic [SEQ_W-1:0] seq,
                        input logic [TIME_W-1:0] ts, input logic [HDL_W-1:0] hdl);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.req_type       <= code;
        req_if.sequence_req   <= seq;
        req_if.capture_time   <= ts;
        req_if.payload_handle <= hdl;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        if (code != REQ_UNUSED) begin
            items_sent++;
        end
    endtask

    // Stop sending, let every predicted frame drain out, then let a trailing
    // walk (skips with no release) finish. pending is updated by nonblocking
    // assignment, so it is first read after the next clock edge.
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_depth(input logic [TGT_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random traffic: mostly a live stream with mild reordering and periodic
    // drains, plus duplicates, slot collisions, stray sequences, clears and
    // the unused code.
    task automatic random_item();
        int               roll;
        logic [SEQ_W-1:0] s;
        roll = $urandom_range(0, 99);
        if (roll < 52) begin
            // late/early arrival within a few sequence numbers of the stream
            s           = win_next + $urandom_range(0, 6) - 3;
            win_next    = win_next + 1;
            last_pushed = s;
            send(REQ_PUSH, s, rand_time(), HDL_W'($urandom));
        end else if (roll < 78) begin
            send(REQ_DRAIN, $urandom, rand_time(), HDL_W'($urandom));
        end else if (roll < 81) begin
            // full window in order, then one drain: reaches the frame cap
            for (int i = 0; i < NUM_SLOTS; i++) begin
                send(REQ_PUSH, win_next, rand_time(), HDL_W'($urandom));
                win_next = win_next + 1;
            end
            send(REQ_DRAIN, $urandom, rand_time(), HDL_W'($urandom));
        end else if (roll < 85) begin
            send(REQ_PUSH, last_pushed, rand_time(), HDL_W'($urandom));
        end else if (roll < 89) begin
            // same slot, different sequence: evicts the occupant
            send(REQ_PUSH, win_next + NUM_SLOTS * $urandom_range(1, 4000),
                 rand_time(), HDL_W'($urandom));
        end else if (roll < 93) begin
            send(REQ_PUSH, $urandom, rand_time(), HDL_W'($urandom));
        end else if (roll < 96) begin
            send(REQ_UNUSED, $urandom, rand_time(), HDL_W'($urandom));
        end else begin
            send(REQ_CLEAR, $urandom, rand_time(), HDL_W'($urandom));
            // restart the stream: same place, anywhere, or just short of the wrap
            case ($urandom_range(0, 3))
                0: win_next = $urandom;
                1: win_next = 32'hFFFF_FFF0 + $urandom_range(0, 15);
                default: begin
                end
            endcase
        end
    endtask

    initial begin
        int   phase_start;
        logic paused;

        req_if.valid          <= 1'b0;
        req_if.req_type       <= REQ_PUSH;
        req_if.sequence_req   <= '0;
        req_if.capture_time   <= '0;
        req_if.payload_handle <= '0;
        win_next    = 32'hFFFF_FFE8;
        last_pushed = win_next;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset depth of 4 ---
        // drain of an empty store
        send(REQ_DRAIN, '1, '1, '1);
        // field extremes, straddling the sequence wrap
        send(REQ_PUSH, 32'hFFFF_FFFE, '1, '1);
        send(REQ_PUSH, 32'hFFFF_FFFF, '0, '0);
        send(REQ_PUSH, 32'h0000_0000, rand_time(), HDL_W'($urandom));
        // three stored, depth four: not primed yet
        send(REQ_DRAIN, '0, '0, '0);
        send(REQ_PUSH, 32'h0000_0001, rand_time(), HDL_W'($urandom));
        // exact duplicate with another payload is ignored
        send(REQ_PUSH, 32'h0000_0001, rand_time(), HDL_W'($urandom));
        // 33 shares slot 1: evicts sequence 1
        send(REQ_PUSH, 32'h0000_0021, rand_time(), HDL_W'($urandom));
        // releases across the wrap, stops at the hole left by the eviction
        send(REQ_DRAIN, $urandom, rand_time(), HDL_W'($urandom));
        send(REQ_UNUSED, $urandom, rand_time(), HDL_W'($urandom));
        send(REQ_CLEAR, $urandom, rand_time(), HDL_W'($urandom));
        // cleared: nothing expected, nothing released
        send(REQ_DRAIN, $urandom, rand_time(), HDL_W'($urandom));

        // --- directed, zero depth: primes at once, skips every gap ---
        write_depth(7'd0);
        send(REQ_PUSH, 32'd5, rand_time(), HDL_W'($urandom));
        send(REQ_PUSH, 32'd9, rand_time(), HDL_W'($urandom));
        send(REQ_DRAIN, $urandom, rand_time(), HDL_W'($urandom));
        // a far gap: each drain is cut off by the walk limit until 1000 is reached
        send(REQ_CLEAR, $urandom, rand_time(), HDL_W'($urandom));
        send(REQ_PUSH, 32'd0, rand_time(), HDL_W'($urandom));
        send(REQ_PUSH, 32'd1000, rand_time(), HDL_W'($urandom));
        repeat (4) send(REQ_DRAIN, $urandom, rand_time(), HDL_W'($urandom));

        // --- random phases, one depth setting each ---
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_depth(phase_depth[p]);
            steady      = (p == 2 || p == 5);
            paused      = 1'b0;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                random_item();
                // odd phases hold the sender once mid-way until the output runs dry
                if (p % 2 == 1 && !paused && items_sent - phase_start >= 20) begin
                    settle();
                    paused = 1'b1;
                end
            end
            steady = 1'b0;
        end

        settle();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
